// ===== rtl/core/frame_rms_peak_meter_defines.svh =====
// ----------------------------------------------------------------------------
// frame_rms_peak_meter_defines
// assertion macros used by the level meter checker
// ----------------------------------------------------------------------------
`ifndef FRAME_RMS_PEAK_METER_DEFINES_SVH
`define FRAME_RMS_PEAK_METER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg
// widths, state codes and control structs of the frame rms and peak meter
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int MAG_W             = 16;
  localparam int SQ_W              = 31;
  localparam int SUM_W             = 43;
  localparam int COUNT_W           = 13;
  localparam int LEVEL_W           = 16;
  localparam int MAX_FRAME_SAMPLES = 4096;
  localparam int RAD_W             = 2 * LEVEL_W;
  localparam int SREM_W            = LEVEL_W + 2;
  localparam int DIV_STEPS         = SUM_W;
  localparam int ROOT_STEPS        = LEVEL_W;
  localparam int STEP_W            = $clog2(DIV_STEPS);
  localparam int OUT_DATA_W        = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ROOT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic div_step;
    logic root_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pend_last;
  } ctrl_status_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] peak;
    logic [COUNT_W-1:0] count;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/frp_ctrl.sv =====
// ----------------------------------------------------------------------------
// frp_ctrl
// sequencer: input flow control, divide and root step counting, result beat
// ----------------------------------------------------------------------------
`default_nettype none

module frp_ctrl
  import frp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tlast,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (status.pend_last) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_ROOT;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_ROOT: begin
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ST_HOLD;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_HOLD: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // a closing sample waits until the back end is free
  always_comb begin
    s_tready      = !(s_tlast && ((state != ST_IDLE) || status.pend_last));
    m_tvalid      = 1'b0;
    cmd.accept    = s_tvalid && s_tready;
    cmd.load      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.root_step = 1'b0;
    unique case (state)
      ST_IDLE:   cmd.load      = status.pend_last;
      ST_DIVIDE: cmd.div_step  = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_HOLD:   m_tvalid      = 1'b1;
      default:   m_tvalid      = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/frp_accum.sv =====
// ----------------------------------------------------------------------------
// frp_accum
// two-stage accumulator: magnitude and square, then sum, peak and count
// ----------------------------------------------------------------------------
`default_nettype none

module frp_accum
  import frp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                last_sample,
  output ctrl_status_t             status,
  output frame_t                   frame
);

  logic [SAMPLE_W:0]    ext;
  logic [SAMPLE_W:0]    neg;
  logic [MAG_W-1:0]     mag;
  logic [2*MAG_W-1:0]   sq_full;

  logic                 p_valid;
  logic                 p_last;
  logic [MAG_W-1:0]     p_mag;
  logic [SQ_W-1:0]      p_sq;

  logic [SUM_W-1:0]     square_sum;
  logic [LEVEL_W-1:0]   peak_so_far;
  logic [COUNT_W-1:0]   frame_len;

  logic                 room;
  logic [SUM_W-1:0]     sum_upd;
  logic [LEVEL_W-1:0]   peak_upd;
  logic [COUNT_W-1:0]   count_upd;

  assign ext     = {sample[SAMPLE_W-1], sample};
  assign neg     = ~ext + 1'b1;
  assign mag     = sample[SAMPLE_W-1] ? neg[MAG_W-1:0] : ext[MAG_W-1:0];
  assign sq_full = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_last <= last_sample;
      p_mag  <= mag;
      p_sq   <= sq_full[SQ_W-1:0];
    end
  end

  // samples past the frame limit are dropped
  assign room      = frame_len < COUNT_W'(MAX_FRAME_SAMPLES);
  assign sum_upd   = room ? square_sum + SUM_W'(p_sq) : square_sum;
  assign peak_upd  = (room && (p_mag > peak_so_far)) ? p_mag : peak_so_far;
  assign count_upd = room ? frame_len + 1'b1 : frame_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum  <= '0;
      peak_so_far <= '0;
      frame_len   <= '0;
    end else if (p_valid) begin
      if (p_last) begin
        square_sum  <= '0;
        peak_so_far <= '0;
        frame_len   <= '0;
      end else begin
        square_sum  <= sum_upd;
        peak_so_far <= peak_upd;
        frame_len   <= count_upd;
      end
    end
  end

  assign status.pend_last = p_valid && p_last;
  assign frame.sum        = sum_upd;
  assign frame.peak       = peak_upd;
  assign frame.count      = count_upd;

endmodule

`default_nettype wire

// ===== rtl/core/frp_level.sv =====
// ----------------------------------------------------------------------------
// frp_level
// back end: restoring divide of sum by count, then digit-by-digit square root
// ----------------------------------------------------------------------------
`default_nettype none

module frp_level
  import frp_pkg::*;
(
  input  wire logic          clk,
  input  wire ctrl_cmd_t     cmd,
  input  wire frame_t        frame,
  output logic [LEVEL_W-1:0] rms_level,
  output logic [LEVEL_W-1:0] peak_level,
  output logic [COUNT_W-1:0] frame_samples
);

  logic [COUNT_W-1:0]  div_rem;
  logic [COUNT_W-1:0]  divisor;
  logic [SUM_W-1:0]    quo;
  logic [SREM_W-1:0]   srem;
  logic [LEVEL_W-1:0]  root;

  logic [COUNT_W:0]    div_shift;
  logic [COUNT_W:0]    div_diff;
  logic                div_ge;
  logic [SREM_W+1:0]   sq_shift;
  logic [SREM_W+1:0]   sq_trial;
  logic [SREM_W+1:0]   sq_diff;
  logic                sq_ge;

  assign div_shift = {div_rem, quo[SUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, divisor};
  assign div_diff  = div_shift - {1'b0, divisor};

  assign sq_shift  = {srem, quo[RAD_W-1 -: 2]};
  assign sq_trial  = {{(SREM_W-LEVEL_W){1'b0}}, root, 2'b01};
  assign sq_ge     = sq_shift >= sq_trial;
  assign sq_diff   = sq_shift - sq_trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_rem       <= '0;
      divisor       <= frame.count;
      quo           <= frame.sum;
      srem          <= '0;
      root          <= '0;
      peak_level    <= frame.peak;
      frame_samples <= frame.count;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
      quo     <= {quo[SUM_W-2:0], div_ge};
    end else if (cmd.root_step) begin
      // quotient fits in the low RAD_W bits, two radicand bits per step
      srem <= sq_ge ? sq_diff[SREM_W-1:0] : sq_shift[SREM_W-1:0];
      root <= {root[LEVEL_W-2:0], sq_ge};
      quo  <= {quo[SUM_W-3:0], 2'b00};
    end
  end

  assign rms_level = root;

endmodule

`default_nettype wire

// ===== rtl/core/frame_rms_peak_meter.sv =====
// ----------------------------------------------------------------------------
// frame_rms_peak_meter
// Takes one signed 16-bit sample per clock; tlast closes a frame. Each
// closing beat yields one result beat with rms, peak and sample count on a
// 0..32768 scale. Frames longer than 4096 samples keep only the first 4096.
// Per frame end the back end runs 43 divide steps and then 16 root steps;
// the result beat is then offered and holds until taken. Non-closing
// samples keep streaming meanwhile; a closing sample is held off while the
// back end computes or holds a result.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rms_peak_meter
  import frp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  input  wire logic                  s_tlast,   // last_sample
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // rms_level, peak_level, frame_samples
);

  ctrl_cmd_t          cmd;
  ctrl_status_t       status;
  frame_t             frame;
  logic [LEVEL_W-1:0] rms_level;
  logic [LEVEL_W-1:0] peak_level;
  logic [COUNT_W-1:0] frame_samples;

  frp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  frp_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample      (s_tdata),
    .last_sample (s_tlast),
    .status      (status),
    .frame       (frame)
  );

  frp_level u_level (
    .clk           (clk),
    .cmd           (cmd),
    .frame         (frame),
    .rms_level     (rms_level),
    .peak_level    (peak_level),
    .frame_samples (frame_samples)
  );

  assign m_tdata = {(OUT_DATA_W - 2*LEVEL_W - COUNT_W)'(0), frame_samples, peak_level,
                    rms_level};

endmodule

`default_nettype wire

// ===== rtl/core/frp_checker.sv =====
// ----------------------------------------------------------------------------
// frp_checker
// port-level checks of the frame rms and peak meter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rms_peak_meter_defines.svh"

module frp_checker
  import frp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  s_tlast,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  logic [LEVEL_W-1:0] rms;
  logic [LEVEL_W-1:0] peak;
  logic [COUNT_W-1:0] count;

  assign rms   = m_tdata[LEVEL_W-1:0];
  assign peak  = m_tdata[2*LEVEL_W-1:LEVEL_W];
  assign count = m_tdata[2*LEVEL_W+COUNT_W-1:2*LEVEL_W];

  `FRP_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `FRP_ASSERT_NOW(a_rms_below_peak, m_tvalid, rms <= peak, "rms above peak")
  `FRP_ASSERT_NOW(a_peak_range, m_tvalid, peak <= LEVEL_W'(32768), "peak beyond full scale")
  `FRP_ASSERT_NOW(a_count_range, m_tvalid, (count != '0) && (count <= COUNT_W'(MAX_FRAME_SAMPLES)), "frame count out of range")
  `FRP_ASSERT_NEXT(a_no_close_while_busy, s_tvalid && s_tready && s_tlast, !m_tvalid && !(s_tready && s_tlast), "frame closed while back end busy")

endmodule

bind frame_rms_peak_meter frp_checker u_frp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/frame_rms_peak_meter_tb.sv =====
// ----------------------------------------------------------------------------
// frame_rms_peak_meter_tb
// Streams signed 16-bit samples in frames closed by tlast and checks every
// result beat (rms, peak, sample count) against an in-bench level predictor.
// Covers full-scale and zero samples, random frames with idle bursts on both
// sides, and a closing stretch of back-to-back frames with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rms_peak_meter_tb;
  import frp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] peak;
    logic [COUNT_W-1:0] count;
  } frame_levels_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;    // [15:0] sample
  logic                  s_tlast = 1'b0;  // last_sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [15:0] rms, [31:16] peak, [44:32] count

  logic [SUM_W-1:0]   energy_sum = '0;
  logic [LEVEL_W-1:0] peak_mag = '0;
  logic [COUNT_W-1:0] frame_count = '0;
  frame_levels_t      level_q[$];

  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  sink_wait = 0;

  frame_rms_peak_meter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[frame_rms_peak_meter] ERROR");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready  <= 1'b1;
      sink_wait <= 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) m_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready  <= 1'b0;
      sink_wait <= $urandom_range(1, 13);
    end
  end

  function automatic logic [LEVEL_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [23:0] r;
    logic [23:0] t;
    logic [47:0] t_sq;
    r = '0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (24'd1 << b);
      t_sq = 48'(t) * 48'(t);
      if (t_sq <= {5'd0, v}) r = t;
    end
    return r[LEVEL_W-1:0];
  endfunction

  task automatic record_sample(input logic [SAMPLE_W-1:0] smp, input logic closes);
    logic [LEVEL_W-1:0] mag;
    logic [31:0]        sq;
    logic [SUM_W-1:0]   mean_sq;
    frame_levels_t      lv;
    mag = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
    if (frame_count < COUNT_W'(MAX_FRAME_SAMPLES)) begin
      sq = 32'(mag) * 32'(mag);
      energy_sum  = energy_sum + SUM_W'(sq);
      if (mag > peak_mag) peak_mag = mag;
      frame_count = frame_count + 1'b1;
    end
    if (closes) begin
      mean_sq  = energy_sum / SUM_W'(frame_count);
      lv.rms   = floor_root(mean_sq);
      lv.peak  = peak_mag;
      lv.count = frame_count;
      level_q  = {level_q, lv};
      energy_sum  = '0;
      peak_mag    = '0;
      frame_count = '0;
    end
  endtask

  task automatic check_level_beat(input logic [OUT_DATA_W-1:0] beat);
    frame_levels_t want;
    if (level_q.size() == 0) begin
      $error("result beat with nothing expected: %h", beat);
      errors++;
    end else begin
      want = level_q.pop_front();
      if (beat[15:0] !== want.rms) begin
        $error("rms_level: expected %0d, got %0d", want.rms, beat[15:0]);
        errors++;
      end
      if (beat[31:16] !== want.peak) begin
        $error("peak_level: expected %0d, got %0d", want.peak, beat[31:16]);
        errors++;
      end
      if (beat[44:32] !== want.count) begin
        $error("frame_samples: expected %0d, got %0d", want.count, beat[44:32]);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_level_beat(m_tdata);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic closes);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= closes;
    do @(posedge clk); while (!s_tready);
    record_sample(smp, closes);
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (level_q.size() != 0);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int flavor);
    int s;
    case (flavor)
      0: s = $urandom_range(0, 65535) - 32768;
      1: s = $urandom_range(0, 128) - 64;
      2: begin
        case ($urandom_range(0, 4))
          0: s = 32767;
          1: s = -32768;
          2: s = -1;
          3: s = 1;
          default: s = 0;
        endcase
      end
      default: s = $urandom_range(0, 1) ? $urandom_range(30000, 32767)
                                        : -$urandom_range(30000, 32768);
    endcase
    return SAMPLE_W'(s);
  endfunction

  task automatic send_random_frame(input int len);
    int flavor;
    flavor = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) send_sample(pick_sample(flavor), i == len - 1);
  endtask

  task automatic test_extremes();
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0003, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
  endtask

  task automatic test_random_frames(input int n_samples);
    int sent;
    int len;
    sent = 0;
    while (sent < n_samples) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
      send_random_frame(len);
      sent += len;
    end
  endtask

  // no idling: closing beats pile up against the back end
  task automatic test_back_to_back();
    calm = 1'b1;
    for (int i = 0; i < 30; i++) send_sample(pick_sample($urandom_range(0, 3)), 1'b1);
    for (int i = 0; i < 8; i++) send_random_frame($urandom_range(1, 10));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    pause_until_drained();
    test_random_frames(870);
    pause_until_drained();
    test_back_to_back();
    pause_until_drained();
    repeat (80) @(posedge clk);
    errors += level_q.size();
    if (errors == 0) begin
      $display("[frame_rms_peak_meter] OK");
    end else begin
      $display("[frame_rms_peak_meter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
